>>> rtl/core/stack_machine_execute_unit_core_macros.svh
// Assertion macros shared by the stack machine execute unit.
`ifndef STACK_MACHINE_EXECUTE_UNIT_CORE_MACROS_SVH
`define STACK_MACHINE_EXECUTE_UNIT_CORE_MACROS_SVH
// Implication checked at every edge outside reset.
`define SMEU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define SMEU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> rtl/core/smeu_pkg.sv
// Package with opcodes, status codes and shared types of the execute unit.
package smeu_pkg;
  localparam int StackDepth = 256;
  localparam int ProgramDepth = 256;
  localparam int SpW = $clog2(StackDepth);
  localparam int DepW = SpW + 1;

  localparam logic [4:0] OP_PUSH = 5'd0;
  localparam logic [4:0] OP_ADD = 5'd1;
  localparam logic [4:0] OP_SUB = 5'd2;
  localparam logic [4:0] OP_MUL = 5'd3;
  localparam logic [4:0] OP_DIV = 5'd4;
  localparam logic [4:0] OP_MOD = 5'd5;
  localparam logic [4:0] OP_REM = 5'd6;
  localparam logic [4:0] OP_LT = 5'd7;
  localparam logic [4:0] OP_GT = 5'd8;
  localparam logic [4:0] OP_EQ = 5'd9;
  localparam logic [4:0] OP_NOT = 5'd10;
  localparam logic [4:0] OP_AND = 5'd11;
  localparam logic [4:0] OP_OR = 5'd12;
  localparam logic [4:0] OP_DUPE = 5'd13;
  localparam logic [4:0] OP_SWAP = 5'd14;
  localparam logic [4:0] OP_DROP = 5'd15;
  localparam logic [4:0] OP_EMIT = 5'd16;
  localparam logic [4:0] OP_HALT = 5'd17;
  localparam logic [4:0] OP_GOTO = 5'd18;
  localparam logic [4:0] OP_JUMP_UNLESS = 5'd19;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_UNDERFLOW = 3'd1;
  localparam logic [2:0] ST_OVERFLOW = 3'd2;
  localparam logic [2:0] ST_DIV_ZERO = 3'd3;
  localparam logic [2:0] ST_BAD_TARGET = 3'd4;
  localparam logic [2:0] ST_HALTED = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;      // capture the instruction and read the top entry
    logic       cap_a;     // capture the top read data
    logic       cap_b;     // capture the second read data
    logic       div_start; // launch the divider
    logic       finish;    // compute and commit the result
    logic       write2;    // second write of swap
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       is_div;
    logic       div_done;
    logic       is_swap;
  } stat_t;
endpackage

>>> rtl/core/smeu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module smeu_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/core/smeu_div.sv
// Radix-2 restoring divider on 32-bit magnitudes, one quotient bit a cycle.
module smeu_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);
  logic [5:0]  count;
  logic        busy;
  logic [32:0] trial;

  assign trial = {remainder, quotient[31]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 6'd0;
        quotient <= dividend;
        remainder <= '0;
      end else if (busy) begin
        if (trial[32]) begin
          remainder <= {remainder[30:0], quotient[31]};
          quotient <= {quotient[30:0], 1'b0};
        end else begin
          remainder <= trial[31:0];
          quotient <= {quotient[30:0], 1'b1};
        end
        count <= count + 6'd1;
        if (count == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> rtl/core/smeu_ctrl.sv
// Controller state machine of the execute unit.
`include "stack_machine_execute_unit_core_macros.svh"
module smeu_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  smeu_pkg::stat_t st,
  output smeu_pkg::ctrl_t cmd
);
  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_CAP, S_DIV, S_EXEC, S_SWAP, S_OUT
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.cap_a = 1'b1;
        state_next = S_CAP;
      end
      S_CAP: begin
        cmd.cap_b = 1'b1;
        if (st.is_div) begin
          state_next = S_DIV;
        end else begin
          state_next = S_EXEC;
        end
      end
      S_DIV: begin
        if (st.div_done) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.finish = 1'b1;
        state_next = st.is_swap ? S_SWAP : S_OUT;
      end
      S_SWAP: begin
        cmd.write2 = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    // The divider is launched on the edge that enters the wait state.
    if (state == S_CAP && st.is_div) begin
      cmd.div_start = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `SMEU_ASSERT_IMP(a_ready_idle, clk, rst, in_ready, !out_valid, "ready while result pending")
  `SMEU_ASSERT_NEXT(a_load_read, clk, rst, cmd.load, state == S_READ, "load not followed by read")
  `SMEU_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")
endmodule

>>> rtl/core/smeu_dp.sv
// Datapath of the execute unit: stack memory, operand registers, ALU.
`include "stack_machine_execute_unit_core_macros.svh"
module smeu_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  smeu_pkg::ctrl_t        cmd,
  output smeu_pkg::stat_t        st,
  input  logic [4:0]             action,
  input  logic signed [31:0]     immediate,
  input  logic [7:0]             instr_address,
  output logic [8:0]             next_address,
  output logic                   print_valid,
  output logic signed [31:0]     print_value,
  output logic [2:0]             status,
  output logic [8:0]             stack_depth
);
  localparam int SpW = smeu_pkg::SpW;
  localparam int DepW = smeu_pkg::DepW;
  localparam logic [DepW-1:0] Full = DepW'(smeu_pkg::StackDepth);
  localparam logic [31:0] PDepth = 32'(smeu_pkg::ProgramDepth);

  logic [4:0]      op;
  logic [31:0]     imm;
  logic [7:0]      addr;
  logic [DepW-1:0] depth;
  logic            halted;
  logic [31:0]     a, b;

  logic            we;
  logic [SpW-1:0]  waddr, raddr;
  logic [31:0]     wdata, rdata;

  logic [31:0] q, r;
  logic        div_done;
  logic [31:0] prod;
  logic [31:0] ma, mb;

  smeu_ram #(.Width(32), .Depth(smeu_pkg::StackDepth)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // The divider starts on the same edge that captures b, so the dividend
  // is taken straight from the read data.
  assign ma = a[31] ? (32'd0 - a) : a;
  assign mb = rdata[31] ? (32'd0 - rdata) : rdata;

  smeu_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(mb), .divisor(ma),
    .done(div_done), .quotient(q), .remainder(r)
  );

  logic is_bin;
  assign is_bin = (op >= smeu_pkg::OP_ADD) && (op <= smeu_pkg::OP_OR) &&
                  (op != smeu_pkg::OP_NOT);

  assign st.is_div = !halted && is_bin && (depth >= DepW'(2)) && (a != 32'd0) &&
                     (op == smeu_pkg::OP_DIV || op == smeu_pkg::OP_MOD ||
                      op == smeu_pkg::OP_REM);
  assign st.div_done = div_done;
  assign st.is_swap = !halted && op == smeu_pkg::OP_SWAP && depth >= DepW'(2);

  // Reads: top entry on load, second entry in the cycle after.
  always_comb begin
    if (cmd.load) begin
      raddr = SpW'(depth - DepW'(1));
    end else begin
      raddr = SpW'(depth - DepW'(2));
    end
  end

  // Result computation for the execute step.
  logic [31:0]     t, wv;
  logic [2:0]      stat_c;
  logic [8:0]      next_c;
  logic [DepW-1:0] dep_c;
  logic            wr_c, pv_c, halt_c;
  logic [SpW-1:0]  wa_c;

  always_ff @(posedge clk) begin
    if (cmd.cap_b) begin
      prod <= rdata * a;
    end
  end

  always_comb begin
    t = 32'd0;
    case (op)
      smeu_pkg::OP_ADD: t = b + a;
      smeu_pkg::OP_SUB: t = b - a;
      smeu_pkg::OP_MUL: t = prod;
      smeu_pkg::OP_DIV: t = ((a[31] ^ b[31]) != 1'b0) ? (32'd0 - q) : q;
      smeu_pkg::OP_MOD: t = r;
      smeu_pkg::OP_REM: t = b[31] ? (32'd0 - r) : r;
      smeu_pkg::OP_LT: t = {31'd0, $signed(b) < $signed(a)};
      smeu_pkg::OP_GT: t = {31'd0, $signed(a) < $signed(b)};
      smeu_pkg::OP_EQ: t = {31'd0, a == b};
      smeu_pkg::OP_AND: t = {31'd0, a == 32'd1 && b == 32'd1};
      smeu_pkg::OP_OR: t = {31'd0, a == 32'd1 || b == 32'd1};
      default: t = 32'd0;
    endcase
  end

  always_comb begin
    stat_c = smeu_pkg::ST_OK;
    next_c = {1'b0, addr} + 9'd1;
    dep_c = depth;
    wr_c = 1'b0;
    wa_c = SpW'(depth - DepW'(2));
    wv = t;
    pv_c = 1'b0;
    halt_c = halted;
    if (halted) begin
      stat_c = smeu_pkg::ST_HALTED;
    end else if (is_bin) begin
      if (depth < DepW'(2)) begin
        stat_c = smeu_pkg::ST_UNDERFLOW;
      end else if (a == 32'd0 && (op == smeu_pkg::OP_DIV || op == smeu_pkg::OP_MOD ||
                                   op == smeu_pkg::OP_REM)) begin
        stat_c = smeu_pkg::ST_DIV_ZERO;
      end else begin
        wr_c = 1'b1;
        dep_c = depth - DepW'(1);
      end
    end else begin
      case (op)
        smeu_pkg::OP_PUSH: begin
          if (depth >= Full) begin
            stat_c = smeu_pkg::ST_OVERFLOW;
          end else begin
            wr_c = 1'b1; wa_c = SpW'(depth); wv = imm; dep_c = depth + DepW'(1);
          end
        end
        smeu_pkg::OP_NOT: begin
          if (depth < DepW'(1)) begin
            stat_c = smeu_pkg::ST_UNDERFLOW;
          end else begin
            wr_c = 1'b1; wa_c = SpW'(depth - DepW'(1)); wv = {31'd0, a == 32'd0};
          end
        end
        smeu_pkg::OP_DUPE: begin
          if (depth < DepW'(1)) begin
            stat_c = smeu_pkg::ST_UNDERFLOW;
          end else if (depth >= Full) begin
            stat_c = smeu_pkg::ST_OVERFLOW;
          end else begin
            wr_c = 1'b1; wa_c = SpW'(depth); wv = a; dep_c = depth + DepW'(1);
          end
        end
        smeu_pkg::OP_SWAP: begin
          if (depth < DepW'(2)) begin
            stat_c = smeu_pkg::ST_UNDERFLOW;
          end else begin
            wr_c = 1'b1; wa_c = SpW'(depth - DepW'(1)); wv = b;
          end
        end
        smeu_pkg::OP_DROP: begin
          if (depth < DepW'(1)) begin
            stat_c = smeu_pkg::ST_UNDERFLOW;
          end else begin
            dep_c = depth - DepW'(1);
          end
        end
        smeu_pkg::OP_EMIT: begin
          if (depth < DepW'(1)) begin
            stat_c = smeu_pkg::ST_UNDERFLOW;
          end else begin
            pv_c = 1'b1; dep_c = depth - DepW'(1);
          end
        end
        smeu_pkg::OP_HALT: begin
          halt_c = 1'b1; stat_c = smeu_pkg::ST_HALTED;
        end
        smeu_pkg::OP_GOTO: begin
          if (depth < DepW'(1)) begin
            stat_c = smeu_pkg::ST_UNDERFLOW;
          end else if (a > PDepth) begin
            stat_c = smeu_pkg::ST_BAD_TARGET;
          end else begin
            next_c = a[8:0]; dep_c = depth - DepW'(1);
          end
        end
        smeu_pkg::OP_JUMP_UNLESS: begin
          if (depth < DepW'(2)) begin
            stat_c = smeu_pkg::ST_UNDERFLOW;
          end else if (b != 32'd1) begin
            if (a > PDepth) begin
              stat_c = smeu_pkg::ST_BAD_TARGET;
            end else begin
              next_c = a[8:0]; dep_c = depth - DepW'(2);
            end
          end else begin
            dep_c = depth - DepW'(2);
          end
        end
        default: ;
      endcase
    end
    if (stat_c != smeu_pkg::ST_OK) begin
      next_c = {1'b0, addr};
    end
  end

  always_comb begin
    we = 1'b0;
    waddr = wa_c;
    wdata = wv;
    if (cmd.finish) begin
      we = wr_c;
    end else if (cmd.write2) begin
      we = 1'b1;
      waddr = SpW'(depth - DepW'(2));
      wdata = a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
      halted <= 1'b0;
    end else if (cmd.finish) begin
      depth <= dep_c;
      halted <= halt_c;
    end
    if (cmd.load) begin
      op <= action;
      imm <= immediate;
      addr <= instr_address;
    end
    if (cmd.cap_a) begin
      a <= rdata;
    end
    if (cmd.cap_b) begin
      b <= rdata;
    end
    if (cmd.finish) begin
      next_address <= next_c;
      print_valid <= pv_c;
      print_value <= pv_c ? a : 32'sd0;
      status <= stat_c;
      stack_depth <= 9'(dep_c);
    end
  end

  `SMEU_ASSERT_IMP(a_depth_range, clk, rst, 1'b1, depth <= Full, "stack depth beyond capacity")
  `SMEU_ASSERT_NEXT(a_halt_sticky, clk, rst, halted, halted, "halt flag cleared without reset")
  `SMEU_ASSERT_IMP(a_one_cmd, clk, rst, 1'b1, $onehot0({cmd.load, cmd.finish, cmd.write2}), "command overlap")
endmodule

>>> rtl/core/stack_machine_execute_unit_core.sv
// Top level of the stack machine execute unit.
// Usage: present one instruction (action, immediate, instr_address) on the
// input channel with in_valid; it is taken when in_ready is also high. One
// result transaction follows on the output channel with out_valid, holding
// next_address, print flag and value, status and the stack depth after the
// instruction. Only one instruction is in flight: in_ready is high only
// while the unit is idle.
// out_valid rises after the two registered reads of the stack RAM and the
// execute step; swap adds a step for its second write. Div, mod and rem
// wait for the radix-2 divider as well, unless they end in an error status.
// A new instruction is accepted only after the last result is taken.
// When the receiver stalls, the result holds on the outputs until it is
// taken, and no new instruction is accepted. Reset empties the stack and
// clears the halted flag; stack contents are not cleared.
module stack_machine_execute_unit_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [4:0]         action,
  input  logic signed [31:0] immediate,
  input  logic [7:0]         instr_address,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [8:0]         next_address,
  output logic               print_valid,
  output logic signed [31:0] print_value,
  output logic [2:0]         status,
  output logic [8:0]         stack_depth
);
  smeu_pkg::ctrl_t cmd;
  smeu_pkg::stat_t st;

  smeu_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .st(st), .cmd(cmd)
  );

  smeu_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st), .action(action),
    .immediate(immediate), .instr_address(instr_address),
    .next_address(next_address), .print_valid(print_valid),
    .print_value(print_value), .status(status), .stack_depth(stack_depth)
  );
endmodule
